[rtl/frc_pkg.sv]
// Shared types and constants for the FIFO-replacement cache.
// Used by frc_front, frc_engine and fifo_replacement_cache_unit; no dependencies.
package frc_pkg;

   localparam int KEY_W   = 16;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = 4;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request code carried in req_type
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] fill_value;
   } req_payload_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] hit_value;
      logic [SLOT_W-1:0]  slot;
      logic               evicted;
   } rsp_payload_type;

   typedef enum logic {
      OP_LOOKUP,
      OP_INSERT
   } op_type;

   // classified request handed from the front queue to the engine
   typedef struct packed {
      logic               valid;
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] fill_value;
   } cmd_type;

   typedef enum logic {
      ENG_IDLE,
      ENG_SCAN
   } engine_state_type;

endpackage

[rtl/frc_front.sv]
// Front end of the cache: two-entry request queue and request decode.
// Depends on frc_pkg.
module frc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  frc_pkg::req_payload_type req_payload,
   output frc_pkg::cmd_type        cmd,
   input  logic                    cmd_pop
);
   import frc_pkg::*;

   req_payload_type q_ff [2];
   logic [1:0]      count_ff, count_in;
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic            push_ok, pop_ok;
   req_payload_type head;

   assign full    = (count_ff == 2'd2);
   assign push_ok = push && !full;
   assign pop_ok  = cmd_pop && (count_ff != 2'd0);
   assign head    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   // decode the request type into an operation
   always_comb begin
      cmd.valid      = (count_ff != 2'd0);
      cmd.op         = (head.req_type == REQ_INSERT) ? OP_INSERT : OP_LOOKUP;
      cmd.key        = head.key;
      cmd.fill_value = head.fill_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

[rtl/frc_engine.sv]
// Back end of the cache: entry memory, key scan, FIFO replacement and result register.
// Depends on frc_pkg.
module frc_engine #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [frc_pkg::CAP_W-1:0] capacity,
   input  frc_pkg::cmd_type         cmd,
   output logic                     cmd_pop,
   output logic                     empty,
   input  logic                     pop,
   output frc_pkg::rsp_payload_type rsp_payload
);
   import frc_pkg::*;

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
   localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int ENTRY_W = KEY_W + STORE_W;

   logic [ENTRY_W-1:0] entry_ff [DEPTH];

   engine_state_type  state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [KEY_W-1:0]  rd_key_ff;
   logic [STORE_W-1:0] rd_val_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              start, match, last, issue, rsp_load;
   logic              mem_we;
   logic [IDX_W-1:0]  wr_addr;
   logic [CMP_W-1:0]  cap_raw, cap_eff, fill_w, rp_w, repl_w, repl_next;
   logic [31:0]       slot_wide;

   assign empty       = !rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign start = (state_ff == ENG_IDLE) && cmd.valid && !rsp_valid_ff;
   assign match = rd_vld_ff && (rd_key_ff == key_ff);
   assign last  = rd_vld_ff && ((CMP_W'(rd_idx_ff) + CMP_W'(1)) == CMP_W'(fill_ff));
   assign issue = (state_ff == ENG_SCAN) && (scan_ff < fill_ff);

   // clamp the capacity register to 1..DEPTH
   always_comb begin
      cap_raw = CMP_W'(capacity);
      cap_eff = cap_raw;
      if (cap_raw == CMP_W'(0)) begin
         cap_eff = CMP_W'(1);
      end else if (cap_raw > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end
      fill_w    = CMP_W'(fill_ff);
      rp_w      = CMP_W'(rp_ff);
      repl_w    = (rp_w >= cap_eff) ? CMP_W'(0) : rp_w;
      repl_next = ((repl_w + CMP_W'(1)) >= cap_eff) ? CMP_W'(0) : (repl_w + CMP_W'(1));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (start && (cmd.op == OP_LOOKUP) && (fill_ff != CNT_W'(0))) begin
               state_in = ENG_SCAN;
            end
         end
         ENG_SCAN: begin
            if (match || last) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      wr_addr   = fill_ff[IDX_W-1:0];
      fill_in   = fill_ff;
      rp_in     = rp_ff;
      scan_in   = scan_ff;
      key_in    = key_ff;
      rd_vld_in = 1'b0;
      rsp_load  = 1'b0;
      slot_wide = 32'd0;
      rsp_in    = '0;
      unique case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               cmd_pop = 1'b1;
               if (cmd.op == OP_INSERT) begin
                  mem_we   = 1'b1;
                  rsp_load = 1'b1;
                  if (fill_w < cap_eff) begin
                     wr_addr = fill_ff[IDX_W-1:0];
                     fill_in = fill_ff + CNT_W'(1);
                  end else begin
                     wr_addr        = repl_w[IDX_W-1:0];
                     rp_in          = repl_next[IDX_W-1:0];
                     rsp_in.evicted = 1'b1;
                  end
                  slot_wide   = 32'(wr_addr);
                  rsp_in.slot = slot_wide[SLOT_W-1:0];
               end else if (fill_ff == CNT_W'(0)) begin
                  // nothing filled: miss at once
                  rsp_load = 1'b1;
               end else begin
                  key_in  = cmd.key;
                  scan_in = CNT_W'(0);
               end
            end
         end
         ENG_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            rd_vld_in = issue && !(match || last);
            if (match) begin
               rsp_load         = 1'b1;
               rsp_in.hit       = 1'b1;
               rsp_in.hit_value = VALUE_W'(rd_val_ff);
               slot_wide        = 32'(rd_idx_ff);
               rsp_in.slot      = slot_wide[SLOT_W-1:0];
            end else if (last) begin
               rsp_load = 1'b1;
            end
         end
         default: begin
            rd_vld_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         fill_ff      <= '0;
         rp_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rp_ff        <= rp_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      key_ff  <= key_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_ff[wr_addr] <= {cmd.key, cmd.fill_value[STORE_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_key_ff <= entry_ff[scan_ff[IDX_W-1:0]][ENTRY_W-1:STORE_W];
         rd_val_ff <= entry_ff[scan_ff[IDX_W-1:0]][STORE_W-1:0];
         rd_idx_ff <= scan_ff[IDX_W-1:0];
      end
   end

endmodule

[rtl/fifo_replacement_cache_unit.sv]
// Top level of the FIFO-replacement cache: capacity register, front queue and engine.
// Depends on frc_pkg, frc_front and frc_engine.
//
//   channel   handshake          payload                       moves
//   -------   ----------------   ---------------------------   ---------------------------
//   request   push / full        req_payload (req_payload_type) lookup or insert request
//   result    empty / pop        rsp_payload (rsp_payload_type) one result per request
//   config    csr_wr_en          csr_wr_data (5 bits)          capacity_in_use
//
// An insert is written and answered in the engine's idle state. A lookup starts, then
// reads the filled entries in order and compares each read with the key, stopping
// early on a hit; the single read port of the entry memory, scanned one entry a cycle,
// sets its pace. Requests wait in a two-deep queue in front of the engine.
// Reset clears the queue, engine state, fill count and replace pointer, not the entries.
// A waiting result stalls the engine start, not the request queue.
module fifo_replacement_cache_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  frc_pkg::req_payload_type  req_payload,
   output logic                      empty,
   input  logic                      pop,
   output frc_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [frc_pkg::CAP_W-1:0] csr_wr_data
);
   import frc_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   cmd_type          cmd;
   logic             cmd_pop;

   // hold the capacity unless written
   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   frc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   frc_engine #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .capacity    (cap_ff),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );

endmodule
